// ===== rtl/murmur3_32_hash_assert.svh =====
// Assertion macros shared by the murmur3_32_hash checker.
`ifndef MURMUR3_32_HASH_ASSERT_SVH
`define MURMUR3_32_HASH_ASSERT_SVH

// Checked in the cycle after the antecedent, masked while in reset.
`define MM3H_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked in the cycle after the antecedent, active through reset.
`define MM3H_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mm3h_pkg.sv =====
// Constants, types and helpers for the murmur3_32_hash block.
package mm3h_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    kind_t       kind;
    logic        last;
  } entry_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

// ===== rtl/mm3h_front.sv =====
// Input side: accepts words, saturates the byte count and masks tail bytes.
module mm3h_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_data_word,
  input  logic [2:0]       in_valid_bytes,
  input  logic             in_last,
  input  logic             q_full,
  output logic             push,
  output mm3h_pkg::entry_t push_entry
);

  logic [2:0] count;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    // only the last word may be short; counts above four saturate
    if (!in_last || in_valid_bytes >= 3'd4) begin
      count = 3'd4;
    end else begin
      count = in_valid_bytes;
    end

    push_entry.count = count;
    push_entry.last  = in_last;

    case (count)
      3'd0: begin
        push_entry.word = 32'h0;
        push_entry.kind = mm3h_pkg::KIND_NONE;
      end
      3'd1: begin
        push_entry.word = in_data_word & 32'h0000_00ff;
        push_entry.kind = mm3h_pkg::KIND_TAIL;
      end
      3'd2: begin
        push_entry.word = in_data_word & 32'h0000_ffff;
        push_entry.kind = mm3h_pkg::KIND_TAIL;
      end
      3'd3: begin
        push_entry.word = in_data_word & 32'h00ff_ffff;
        push_entry.kind = mm3h_pkg::KIND_TAIL;
      end
      default: begin
        push_entry.word = in_data_word;
        push_entry.kind = mm3h_pkg::KIND_FULL;
      end
    endcase
  end

endmodule

// ===== rtl/mm3h_queue.sv =====
// Small FIFO of classified words between the front and the hash unit.
module mm3h_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mm3h_pkg::entry_t push_entry,
  input  logic             pop,
  output mm3h_pkg::entry_t pop_entry,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mm3h_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/mm3h_back.sv =====
// Hash unit: sequences block mix, hash update, finish mix and result register.
module mm3h_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      seed,
  input  logic             q_empty,
  input  mm3h_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_hash_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } state_t;

  state_t      state_r, state_nxt;
  logic        start_r, start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] k_r, k_nxt;
  logic        kind_full_r, kind_full_nxt;
  logic        last_r, last_nxt;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    logic [31:0] h;
    logic [31:0] x;
    logic        out_free;

    h             = 32'h0;
    x             = 32'h0;
    out_free      = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    hash_nxt      = hash_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    kind_full_nxt = kind_full_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          // seed and length restart on the first word of a message
          hash_nxt      = start_r ? seed : hash_r;
          len_nxt       = (start_r ? 32'h0 : len_r) + {29'h0, q_entry.count};
          start_nxt     = 1'b0;
          k_nxt         = q_entry.word;
          kind_full_nxt = (q_entry.kind == mm3h_pkg::KIND_FULL);
          last_nxt      = q_entry.last;
          state_nxt     = (q_entry.kind == mm3h_pkg::KIND_NONE) ? S_FIN0 : S_MUL1;
        end
      end
      S_MUL1: begin
        k_nxt     = k_r * mm3h_pkg::MIX_C1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        k_nxt     = mm3h_pkg::rotl15(k_r) * mm3h_pkg::MIX_C2;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        h = hash_r ^ k_r;
        if (kind_full_r) begin
          x = mm3h_pkg::rotl13(h);
          h = {x[29:0], 2'b00} + x + mm3h_pkg::MIX_ADD;
        end
        hash_nxt  = h;
        state_nxt = last_r ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        x         = hash_r ^ len_r;
        k_nxt     = x ^ (x >> 16);
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        k_nxt     = k_r * mm3h_pkg::FIN_M1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        x         = k_r ^ (k_r >> 13);
        k_nxt     = x * mm3h_pkg::FIN_M2;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        // wait here until the result register is free
        if (out_free) begin
          out_hash_nxt  = k_r ^ (k_r >> 16);
          out_valid_nxt = 1'b1;
          start_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hash_r  <= out_hash_nxt;
    hash_r      <= hash_nxt;
    len_r       <= len_nxt;
    k_r         <= k_nxt;
    kind_full_r <= kind_full_nxt;
    last_r      <= last_nxt;
  end

endmodule

// ===== rtl/murmur3_32_hash.sv =====
// MurmurHash3 x86 32-bit hash of a word stream. The front end takes a word in any cycle
// the queue (QUEUE_DEPTH entries) has room and classifies it; the hash unit then steps
// a word with bytes to mix through dequeue, two multiplier stages and the hash update,
// and only dequeues a zero-byte last word; the last word of a message then runs the
// finish states FIN0 to FIN3 before the hash lands in the output register. The hash
// unit takes no new word before it is through with the last one. The seed register is
// sampled when the first word of a message leaves the queue.
module murmur3_32_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]      hash_seed_r;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  mm3h_pkg::entry_t push_entry;
  mm3h_pkg::entry_t pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= 32'h0;
    end else if (cfg_we) begin
      hash_seed_r <= cfg_wdata;
    end
  end

  mm3h_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  mm3h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  mm3h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (hash_seed_r),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

// ===== rtl/mm3h_checker.sv =====
// Port-level checker for murmur3_32_hash and its bind.
`include "murmur3_32_hash_assert.svh"

module mm3h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value
);

  `MM3H_ASSERT_NXT(a_out_valid_held, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MM3H_ASSERT_NXT(a_out_data_held, clk, rst_n, out_valid && out_stall, $stable(out_hash_value), "result changed while stalled")
  `MM3H_ASSERT_RST(a_reset_clear, clk, !rst_n, !out_valid && !in_stall, "reset left a result or a full queue")
  `MM3H_ASSERT_RST(a_reset_latency, clk, !rst_n, ##5 !out_valid, "result appeared too soon after reset")

endmodule

bind murmur3_32_hash mm3h_checker u_mm3h_checker (.*);
